[rtl/core/rlpc_pkg.sv]
// rlpc_pkg: state codes, reset constants and evaluation structs for the
// reversing loop polarity controller. No dependencies.
`default_nettype none

package rlpc_pkg;

    localparam int unsigned TIMER_BITS_DEF   = 20;
    localparam int unsigned TIMEOUT_W        = 20;
    localparam int unsigned LOST_TIMEOUT_RST = 60000;
    localparam int unsigned NUM_DET          = 5;

    // controller states
    localparam logic [3:0] ST_OFF      = 4'd0;
    localparam logic [3:0] ST_PRE_A    = 4'd1;
    localparam logic [3:0] ST_IN_A     = 4'd2;
    localparam logic [3:0] ST_LEAVE_B  = 4'd3;
    localparam logic [3:0] ST_PRE_B    = 4'd4;
    localparam logic [3:0] ST_IN_B     = 4'd5;
    localparam logic [3:0] ST_LEAVE_A  = 4'd6;
    localparam logic [3:0] ST_FS_BOTH  = 4'd7;
    localparam logic [3:0] ST_FS_LOWV  = 4'd8;
    localparam logic [3:0] ST_FS_VOFF  = 4'd9;
    localparam logic [3:0] ST_FS_LONG  = 4'd10;

    // request kinds
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // register word indexes
    localparam logic REG_LOST_TIMEOUT = 1'b0;

    // detector levels, left to right across the loop
    typedef struct packed {
        logic ext_b;
        logic int_b;
        logic int_m;
        logic int_a;
        logic ext_a;
    } t_levels;

    typedef struct packed {
        t_levels    lv;
        t_levels    pv;
        logic       volt;
        logic [3:0] state;
        logic       lost;
    } t_eval_req;

    typedef struct packed {
        logic [3:0] state;
        logic       lost;
        logic       start_timer;
    } t_eval_res;

endpackage

`default_nettype wire

[rtl/core/rlpc_eval.sv]
// rlpc_eval: one evaluation of the loop state machine, edge and direction
// detection included. Purely combinational. Depends on rlpc_pkg.
`default_nettype none

module rlpc_eval (
    input  rlpc_pkg::t_eval_req i_req,
    output rlpc_pkg::t_eval_res o_res
);
    import rlpc_pkg::*;

    logic ea_fell, eb_fell, ia_rose, im_rose, ib_rose;
    logic loop_clear, all_clear, inside_loop, to_a, to_b, was_inside;
    logic in_use, lost_mid, left_loop;
    logic [3:0] s;
    t_levels lv, pv;

    always_comb begin
        lv = i_req.lv;
        pv = i_req.pv;

        ea_fell = !lv.ext_a && pv.ext_a;
        eb_fell = !lv.ext_b && pv.ext_b;
        ia_rose = lv.int_a && !pv.int_a;
        im_rose = lv.int_m && !pv.int_m;
        ib_rose = lv.int_b && !pv.int_b;

        loop_clear  = !lv.int_a && !lv.int_m && !lv.int_b;
        all_clear   = loop_clear && !lv.ext_a && !lv.ext_b;
        inside_loop = !loop_clear && !lv.ext_a && !lv.ext_b;
        to_a = inside_loop && (ia_rose || (im_rose && lv.int_b && !lv.int_a) || eb_fell);
        to_b = inside_loop && (ib_rose || (im_rose && lv.int_a && !lv.int_b) || ea_fell);
        was_inside = (pv.int_a || pv.int_m || pv.int_b) && !pv.ext_a && !pv.ext_b;

        in_use = i_req.state inside {ST_IN_A, ST_LEAVE_B, ST_IN_B, ST_LEAVE_A};

        // train gone from every detector while in the loop: start waiting
        o_res.start_timer = 1'b0;
        lost_mid          = i_req.lost;
        if (all_clear && was_inside && in_use && !i_req.lost) begin
            lost_mid          = 1'b1;
            o_res.start_timer = 1'b1;
        end else if (!all_clear && i_req.lost) begin
            lost_mid = 1'b0;
        end
        left_loop = all_clear && !lost_mid;

        s = i_req.state;
        case (i_req.state)
            ST_OFF: begin
                if (i_req.volt)                s = ST_FS_VOFF;
                else if (lv.ext_a && !lv.ext_b) s = ST_PRE_A;
                else if (lv.ext_b && !lv.ext_a) s = ST_PRE_B;
            end
            ST_PRE_A: begin
                if (!i_req.volt)    s = ST_FS_LOWV;
                else if (lv.ext_b)  s = ST_FS_BOTH;
                else if (lv.int_a)  s = ST_IN_A;
                else if (!lv.ext_a) s = ST_OFF;
            end
            ST_IN_A: begin
                if (!i_req.volt)                 s = ST_FS_LOWV;
                else if (lv.ext_b)               s = ST_FS_BOTH;
                else if (lv.ext_a && lv.int_b)   s = ST_FS_LONG;
                else if (!lv.ext_a && lv.int_b)  s = ST_LEAVE_B;
                else if (left_loop)              s = ST_OFF;
                else if (loop_clear && lv.ext_a) s = ST_PRE_A;
            end
            ST_LEAVE_B: begin
                if (!i_req.volt)                              s = ST_FS_LOWV;
                else if (to_a)                                s = ST_LEAVE_A;
                else if (left_loop)                           s = ST_OFF;
                else if (loop_clear && lv.ext_b && !lv.ext_a) s = ST_PRE_B;
                else if (loop_clear && lv.ext_a && !lv.ext_b) s = ST_PRE_A;
                else if (loop_clear && lv.ext_a && lv.ext_b)  s = ST_OFF;
            end
            ST_PRE_B: begin
                if (!i_req.volt)    s = ST_FS_LOWV;
                else if (lv.ext_a)  s = ST_FS_BOTH;
                else if (lv.int_b)  s = ST_IN_B;
                else if (!lv.ext_b) s = ST_OFF;
            end
            ST_IN_B: begin
                if (!i_req.volt)                 s = ST_FS_LOWV;
                else if (lv.ext_a)               s = ST_FS_BOTH;
                else if (lv.ext_b && lv.int_a)   s = ST_FS_LONG;
                else if (!lv.ext_b && lv.int_a)  s = ST_LEAVE_A;
                else if (left_loop)              s = ST_OFF;
                else if (loop_clear && lv.ext_b) s = ST_PRE_B;
            end
            ST_LEAVE_A: begin
                if (!i_req.volt)                              s = ST_FS_LOWV;
                else if (to_b)                                s = ST_LEAVE_B;
                else if (left_loop)                           s = ST_OFF;
                else if (loop_clear && lv.ext_a && !lv.ext_b) s = ST_PRE_A;
                else if (loop_clear && lv.ext_b && !lv.ext_a) s = ST_PRE_B;
                else if (loop_clear && lv.ext_a && lv.ext_b)  s = ST_OFF;
            end
            default: begin
                // fail-safe states, and codes that mean nothing
                if (all_clear && !i_req.volt) s = ST_OFF;
            end
        endcase

        o_res.state = s;
        // no waiting for a lost train while off or in fail-safe
        o_res.lost  = (s == ST_OFF || s >= ST_FS_BOTH) ? 1'b0 : lost_mid;
    end

endmodule

`default_nettype wire

[rtl/core/reversing_loop_polarity_controller.sv]
// reversing loop polarity controller: an accepted word reaches its result word
// through the input register, then evaluation into the result register;
// throughput one word per cycle unless the result side stalls; the next-state evaluation is combinational.
// synchronous active-low reset: state off, detectors clear, lost flag and timer
// cleared, timeout register 60000 ticks. depends on rlpc_pkg and rlpc_eval.
`default_nettype none

module reversing_loop_polarity_controller #(
    parameter int unsigned TIMER_BITS = rlpc_pkg::TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic        i_ext_a,
    input  logic        i_int_a,
    input  logic        i_int_m,
    input  logic        i_int_b,
    input  logic        i_ext_b,
    input  logic        i_voltage_present,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic        o_status_changed,
    output logic        o_loop_powered,
    output logic        o_polarity_b,
    output logic        o_train_lost,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rlpc_pkg::*;

    // elapsed and timeout are compared at the wider of the two widths
    localparam int unsigned CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

    // configuration register
    logic [TIMEOUT_W-1:0] r_timeout;

    // input register
    logic    r_in_vld;
    logic    r_in_tick;
    t_levels r_in_lv;
    logic    r_in_volt;

    // controller state
    logic [3:0]            r_state, n_state;
    t_levels               r_prev, n_prev;
    logic                  r_volt, n_volt;
    logic                  r_lost, n_lost;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;

    // result register
    logic       r_out_vld;
    logic [3:0] r_status;
    logic       r_changed;
    logic       r_powered;
    logic       r_pol_b;
    logic       r_lost_o;

    logic                  out_free, take_in, do_work;
    logic                  do_eval, timed_out;
    logic [TIMER_BITS-1:0] elapsed_inc;
    t_eval_req             ev_req;
    t_eval_res             ev_res;

    // ---------------------------------------------------------------
    // configuration: single word, pready tied high
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_W'(LOST_TIMEOUT_RST);
        end else if (psel && penable && pwrite && paddr[2] == REG_LOST_TIMEOUT) begin
            r_timeout <= pwdata[TIMEOUT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LOST_TIMEOUT) prdata[TIMEOUT_W-1:0] = r_timeout;
    end

    // ---------------------------------------------------------------
    // handshake: the input register holds only while a result is stuck
    // ---------------------------------------------------------------
    assign out_free   = !r_out_vld || !i_out_stall;
    assign do_work    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign take_in    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take_in) begin
            r_in_vld <= 1'b1;
        end else if (do_work) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_tick     <= i_req_type;
            r_in_lv.ext_a <= i_ext_a;
            r_in_lv.int_a <= i_int_a;
            r_in_lv.int_m <= i_int_m;
            r_in_lv.int_b <= i_int_b;
            r_in_lv.ext_b <= i_ext_b;
            r_in_volt     <= i_voltage_present;
        end
    end

    // ---------------------------------------------------------------
    // lost-train timer: saturating count, fires when the incremented count >= timeout
    // ---------------------------------------------------------------
    assign elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
    assign timed_out   = CMP_W'(elapsed_inc) >= CMP_W'(r_timeout);

    // an update always evaluates; a tick only when a lost train times out,
    // and then with the stored levels as both current and previous
    always_comb begin
        do_eval = (r_in_tick == REQ_UPDATE) || (r_lost && timed_out);

        ev_req.lv    = (r_in_tick == REQ_UPDATE) ? r_in_lv : r_prev;
        ev_req.pv    = r_prev;
        ev_req.volt  = (r_in_tick == REQ_UPDATE) ? r_in_volt : r_volt;
        ev_req.state = r_state;
        ev_req.lost  = (r_in_tick == REQ_UPDATE) ? r_lost : 1'b0;
    end

    rlpc_eval u_eval (
        .i_req (ev_req),
        .o_res (ev_res)
    );

    always_comb begin
        n_state   = r_state;
        n_prev    = r_prev;
        n_volt    = r_volt;
        n_lost    = r_lost;
        n_elapsed = r_elapsed;

        if (r_in_tick == REQ_UPDATE) n_volt = r_in_volt;
        if (r_in_tick == REQ_TICK && r_lost) n_elapsed = elapsed_inc;

        if (do_eval) begin
            n_state = ev_res.state;
            n_prev  = ev_req.lv;
            n_lost  = ev_res.lost;
            if (ev_res.start_timer) n_elapsed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_OFF;
            r_prev    <= '0;
            r_volt    <= 1'b0;
            r_lost    <= 1'b0;
            r_elapsed <= '0;
        end else if (do_work) begin
            r_state   <= n_state;
            r_prev    <= n_prev;
            r_volt    <= n_volt;
            r_lost    <= n_lost;
            r_elapsed <= n_elapsed;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= do_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_work) begin
            r_status  <= n_state;
            r_changed <= (n_state != r_state);
            r_powered <= (n_state >= ST_PRE_A) && (n_state <= ST_LEAVE_A);
            r_pol_b   <= (n_state >= ST_LEAVE_B) && (n_state <= ST_IN_B);
            r_lost_o  <= n_lost;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_status;
    assign o_status_changed = r_changed;
    assign o_loop_powered   = r_powered;
    assign o_polarity_b     = r_pol_b;
    assign o_train_lost     = r_lost_o;

endmodule

`default_nettype wire

[test/reversing_loop_polarity_controller_tb.sv]
// self-checking testbench for the reversing loop polarity controller: directed table,
// then train passages, ticks and noise checked against an in-bench predictor.
// depends on rlpc_pkg and the reversing_loop_polarity_controller rtl.
module reversing_loop_polarity_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlpc_pkg::*;

    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_DRILL   = 25;

    // detector masks, bit 0 is the outer detector on side a
    localparam logic [4:0] D_NONE = 5'b00000;
    localparam logic [4:0] D_EA   = 5'b00001;
    localparam logic [4:0] D_IA   = 5'b00010;
    localparam logic [4:0] D_IM   = 5'b00100;
    localparam logic [4:0] D_IB   = 5'b01000;
    localparam logic [4:0] D_EB   = 5'b10000;
    localparam logic [4:0] D_ALL  = 5'b11111;

    // one result word as the block reports it
    typedef struct packed {
        logic [3:0] status;
        logic       changed;
        logic       powered;
        logic       pol_b;
        logic       lost;
    } t_loop_status;

    // one row of the directed table; want is only used where typed is set
    typedef struct packed {
        logic         rt;
        logic [4:0]   lv;
        logic         v;
        logic         typed;
        t_loop_status want;
    } t_drill_row;

    localparam t_loop_status UNTYPED = '0;

    // directed walk: extremes, off-state specials, a passage a to b with a vanishing
    // train, then the fail-safe states and the way back to off
    localparam t_drill_row DRILL [NUM_DRILL] = '{
        // tick with no lost train and every field high: nothing moves
        '{REQ_TICK,   D_ALL,       1'b1, 1'b1, '{ST_OFF,     1'b0, 1'b0, 1'b0, 1'b0}},
        // trains on both outer sides while off: stays off
        '{REQ_UPDATE, D_EA | D_EB, 1'b0, 1'b1, '{ST_OFF,     1'b0, 1'b0, 1'b0, 1'b0}},
        '{REQ_UPDATE, D_NONE,      1'b1, 1'b1, '{ST_FS_VOFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{REQ_UPDATE, D_NONE,      1'b0, 1'b1, '{ST_OFF,     1'b1, 1'b0, 1'b0, 1'b0}},
        '{REQ_UPDATE, D_EA,        1'b0, 1'b1, '{ST_PRE_A,   1'b1, 1'b1, 1'b0, 1'b0}},
        '{REQ_UPDATE, D_EA | D_IA, 1'b1, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_IA,        1'b1, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_IM,        1'b1, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_IB,        1'b1, 1'b0, UNTYPED},
        // train vanishes inside the loop, a tick, then it shows up again
        '{REQ_UPDATE, D_NONE,      1'b1, 1'b0, UNTYPED},
        '{REQ_TICK,   D_NONE,      1'b0, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_IB,        1'b1, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_EB,        1'b1, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_EB | D_IB, 1'b1, 1'b0, UNTYPED},
        // train too long, then fail-safe held while voltage is present
        '{REQ_UPDATE, D_EB | D_IA, 1'b1, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_NONE,      1'b1, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_NONE,      1'b0, 1'b1, '{ST_OFF,     1'b1, 1'b0, 1'b0, 1'b0}},
        '{REQ_UPDATE, D_EA,        1'b0, 1'b1, '{ST_PRE_A,   1'b1, 1'b1, 1'b0, 1'b0}},
        '{REQ_UPDATE, D_EA | D_EB, 1'b1, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_NONE,      1'b0, 1'b1, '{ST_OFF,     1'b1, 1'b0, 1'b0, 1'b0}},
        '{REQ_UPDATE, D_EB,        1'b0, 1'b1, '{ST_PRE_B,   1'b1, 1'b1, 1'b1, 1'b0}},
        // powered but no voltage: low-voltage fail-safe
        '{REQ_UPDATE, D_EB,        1'b0, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_ALL,       1'b1, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_NONE,      1'b0, 1'b0, UNTYPED},
        '{REQ_UPDATE, D_ALL,       1'b1, 1'b1, '{ST_FS_VOFF, 1'b1, 1'b0, 1'b0, 1'b0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic        i_ext_a;
    logic        i_int_a;
    logic        i_int_m;
    logic        i_int_b;
    logic        i_ext_b;
    logic        i_voltage_present;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_status;
    logic        o_status_changed;
    logic        o_loop_powered;
    logic        o_polarity_b;
    logic        o_train_lost;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the controller
    logic [3:0]                pr_state      = ST_OFF;
    t_levels                   pr_levels     = '0;
    logic                      pr_volt       = 1'b0;
    logic                      pr_lost       = 1'b0;
    logic [TIMER_BITS_DEF-1:0] pr_lost_ticks = '0;
    logic [TIMEOUT_W-1:0]      pr_timeout    = TIMEOUT_W'(LOST_TIMEOUT_RST);

    // result words still owed by the block, oldest first
    t_loop_status status_q[$];

    int          errors       = 0;
    int          words_sent   = 0;
    int          n_updates    = 0;
    int          n_ticks      = 0;
    int          n_timeouts   = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    logic [10:0] states_seen  = '0;

    // idling switches and the request for a long receiver hold-off
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    bit press_req = 1'b0;

    reversing_loop_polarity_controller dut (.*);

    always #10 i_clk = ~i_clk;

    // one evaluation of the state machine against the stored levels
    function automatic void loop_evaluate(input t_levels lv, input logic v);
        t_levels    pv;
        logic       ea, ia, im, ib, eb;
        logic       ea_fell, eb_fell, ia_rose, im_rose, ib_rose;
        logic       loop_clear, all_clear, in_loop, was_in_loop;
        logic       to_a, to_b, in_use, gone;
        logic [3:0] s;
        pv = pr_levels;
        s  = pr_state;
        ea = lv.ext_a;
        ia = lv.int_a;
        im = lv.int_m;
        ib = lv.int_b;
        eb = lv.ext_b;
        // edges against the previous evaluation
        ea_fell = !ea && pv.ext_a;
        eb_fell = !eb && pv.ext_b;
        ia_rose = ia && !pv.int_a;
        im_rose = im && !pv.int_m;
        ib_rose = ib && !pv.int_b;
        loop_clear  = !ia && !im && !ib;
        all_clear   = loop_clear && !ea && !eb;
        in_loop     = !loop_clear && !ea && !eb;
        // direction of travel for a train wholly inside the loop
        to_a        = in_loop && (ia_rose || (im_rose && ib && !ia) || eb_fell);
        to_b        = in_loop && (ib_rose || (im_rose && ia && !ib) || ea_fell);
        was_in_loop = (pv.int_a || pv.int_m || pv.int_b) && !pv.ext_a && !pv.ext_b;
        in_use      = (s == ST_IN_A) || (s == ST_LEAVE_B) || (s == ST_IN_B) ||
                      (s == ST_LEAVE_A);

        // a train that disappears from inside the loop arms the lost timer
        if (all_clear && was_in_loop && in_use && !pr_lost) begin
            pr_lost       = 1'b1;
            pr_lost_ticks = '0;
        end else if (!all_clear && pr_lost) begin
            pr_lost = 1'b0;
        end
        gone = all_clear && !pr_lost;

        case (s)
            ST_OFF: begin
                if (v) s = ST_FS_VOFF;
                else if (ea && !eb) s = ST_PRE_A;
                else if (eb && !ea) s = ST_PRE_B;
            end
            ST_PRE_A: begin
                if (!v) s = ST_FS_LOWV;
                else if (eb) s = ST_FS_BOTH;
                else if (ia) s = ST_IN_A;
                else if (!ea) s = ST_OFF;
            end
            ST_IN_A: begin
                if (!v) s = ST_FS_LOWV;
                else if (eb) s = ST_FS_BOTH;
                else if (ea && ib) s = ST_FS_LONG;
                else if (!ea && ib) s = ST_LEAVE_B;
                else if (gone) s = ST_OFF;
                else if (loop_clear && ea) s = ST_PRE_A;
            end
            ST_LEAVE_B: begin
                if (!v) s = ST_FS_LOWV;
                else if (to_a) s = ST_LEAVE_A;
                else if (gone) s = ST_OFF;
                else if (loop_clear && eb && !ea) s = ST_PRE_B;
                else if (loop_clear && ea && !eb) s = ST_PRE_A;
                else if (loop_clear && ea && eb) s = ST_OFF;
            end
            ST_PRE_B: begin
                if (!v) s = ST_FS_LOWV;
                else if (ea) s = ST_FS_BOTH;
                else if (ib) s = ST_IN_B;
                else if (!eb) s = ST_OFF;
            end
            ST_IN_B: begin
                if (!v) s = ST_FS_LOWV;
                else if (ea) s = ST_FS_BOTH;
                else if (eb && ia) s = ST_FS_LONG;
                else if (!eb && ia) s = ST_LEAVE_A;
                else if (gone) s = ST_OFF;
                else if (loop_clear && eb) s = ST_PRE_B;
            end
            ST_LEAVE_A: begin
                if (!v) s = ST_FS_LOWV;
                else if (to_b) s = ST_LEAVE_B;
                else if (gone) s = ST_OFF;
                else if (loop_clear && ea && !eb) s = ST_PRE_A;
                else if (loop_clear && eb && !ea) s = ST_PRE_B;
                else if (loop_clear && ea && eb) s = ST_OFF;
            end
            default: begin
                // fail-safe: only a clear, dead loop releases it
                if (all_clear && !v) s = ST_OFF;
            end
        endcase

        pr_levels = lv;
        if (s == ST_OFF || s >= ST_FS_BOTH) pr_lost = 1'b0;
        pr_state = s;
    endfunction

    // expected result word for one accepted input word
    function automatic t_loop_status predict_status(input logic rt, input t_levels lv,
                                                    input logic v);
        t_loop_status r;
        logic [3:0]   was;
        was = pr_state;
        if (rt == REQ_UPDATE) begin
            pr_volt = v;
            loop_evaluate(lv, v);
        end else if (pr_lost) begin
            // saturating tick count, timeout re-evaluates on the stored levels
            if (pr_lost_ticks != '1) pr_lost_ticks++;
            if (pr_lost_ticks >= pr_timeout) begin
                pr_lost = 1'b0;
                n_timeouts++;
                loop_evaluate(pr_levels, pr_volt);
            end
        end
        states_seen[pr_state] = 1'b1;
        r.status  = pr_state;
        r.changed = (pr_state != was);
        r.powered = (pr_state >= ST_PRE_A) && (pr_state <= ST_LEAVE_A);
        r.pol_b   = (pr_state >= ST_LEAVE_B) && (pr_state <= ST_IN_B);
        r.lost    = pr_lost;
        return r;
    endfunction

    // offer one word, hold it until accepted, then queue what it should produce
    task automatic put_word(input logic rt, input logic [4:0] lv, input logic v,
                            input logic typed, input t_loop_status want);
        t_loop_status pred;
        if (send_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_req_type        <= rt;
        i_ext_a           <= lv[0];
        i_int_a           <= lv[1];
        i_int_m           <= lv[2];
        i_int_b           <= lv[3];
        i_ext_b           <= lv[4];
        i_voltage_present <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = predict_status(rt, t_levels'(lv), v);
        status_q.push_back(typed ? want : pred);
        words_sent++;
        if (rt == REQ_UPDATE) n_updates++;
        else n_ticks++;
    endtask

    // detector update with the voltage a powered loop would show, now and then wrong
    task automatic send_update(input logic [4:0] lv);
        logic v;
        v = ((pr_state >= ST_PRE_A) && (pr_state <= ST_LEAVE_A)) ^
            ($urandom_range(0, 19) == 0);
        put_word(REQ_UPDATE, lv, v, 1'b0, UNTYPED);
    endtask

    // tick with junk in the ignored fields
    task automatic send_tick();
        put_word(REQ_TICK, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'b0,
                 UNTYPED);
    endtask

    // up to enough ticks to run a short timeout out, a handful for long ones
    function automatic int tick_burst();
        return (pr_timeout <= 30) ? $urandom_range(1, int'(pr_timeout) + 3)
                                  : $urandom_range(1, 8);
    endfunction

    // a train of 1..3 detectors crossing the loop from either side, sometimes
    // turning back inside it or vanishing for a while
    task automatic run_passage();
        int         len, head, dir, turn_at, vanish_at, steps, k;
        bit         from_b;
        logic [4:0] occ, lv;
        len       = $urandom_range(1, 3);
        from_b    = $urandom_range(0, 1);
        turn_at   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : -1;
        vanish_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : -1;
        head      = -1;
        dir       = 1;
        for (steps = 0; steps < 24; steps++) begin
            head += dir;
            for (k = 0; k < 5; k++) occ[k] = (k <= head) && (k > head - len);
            for (k = 0; k < 5; k++) lv[k] = from_b ? occ[4 - k] : occ[k];
            send_update(lv);
            if ($urandom_range(0, 3) == 0) send_tick();
            if (steps == turn_at) dir = -dir;
            if (steps == vanish_at) begin
                send_update(D_NONE);
                repeat (tick_burst()) send_tick();
                if ($urandom_range(0, 1) == 1) break;
            end
            if (occ == D_NONE) break;
        end
    endtask

    // mostly passages, some tick bursts, some noise
    task automatic run_random(input int n);
        int target;
        target = words_sent + n;
        while (words_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1: put_word(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                               1'($urandom_range(0, 1)), 1'b0, UNTYPED);
                2: repeat (tick_burst()) send_tick();
                default: run_passage();
            endcase
        end
    endtask

    // program the lost-train timeout with the block idle, then read it back
    task automatic write_lost_timeout(input logic [TIMEOUT_W-1:0] ticks);
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LOST_TIMEOUT, 2'b00};
        pwdata  <= 32'(ticks);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pr_timeout = ticks;
        // straight into the read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(ticks)) begin
            errors++;
            $display("%0t: timeout register expected %0d, got %0d", $time, ticks, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // compare an accepted result word with the oldest one owed
    task automatic check_status_word();
        t_loop_status want;
        if (status_q.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing expected, status %0d",
                     $time, o_status);
            return;
        end
        want = status_q.pop_front();
        results_seen++;
        check_field("status", want.status, o_status);
        check_field("status_changed", 4'(want.changed), 4'(o_status_changed));
        check_field("loop_powered", 4'(want.powered), 4'(o_loop_powered));
        check_field("polarity_b", 4'(want.pol_b), 4'(o_polarity_b));
        check_field("train_lost", 4'(want.lost), 4'(o_train_lost));
    endtask

    // result side: check accepted words, stall in bursts, long hold-off on request
    initial begin
        int burst, hold;
        burst = 0;
        hold  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) check_status_word();
            if (press_req) begin
                press_req = 1'b0;
                hold      = 80;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (recv_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 13);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run timed out, %0d result words outstanding",
                     $time, status_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus
    initial begin
        int r;
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_req_type        <= REQ_UPDATE;
        i_ext_a           <= 1'b0;
        i_int_a           <= 1'b0;
        i_int_m           <= 1'b0;
        i_int_b           <= 1'b0;
        i_ext_b           <= 1'b0;
        i_voltage_present <= 1'b0;
        i_out_stall       <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset timeout
        for (r = 0; r < NUM_DRILL; r++)
            put_word(DRILL[r].rt, DRILL[r].lv, DRILL[r].v, DRILL[r].typed, DRILL[r].want);

        // zero timeout: the first tick after a loss switches off
        write_lost_timeout('0);
        run_random(400);

        // largest timeout never fires here; fill the block against a long hold-off
        write_lost_timeout('1);
        send_idle = 1'b0;
        press_req = 1'b1;
        run_random(60);
        send_idle = 1'b1;
        run_random(240);

        write_lost_timeout(TIMEOUT_W'(3));
        run_random(400);

        write_lost_timeout(TIMEOUT_W'($urandom_range(1, 30)));
        run_random(350);

        // closing stretch with no idling on either side
        send_idle = 1'b0;
        recv_idle = 1'b0;
        write_lost_timeout(TIMEOUT_W'($urandom_range(4, 12)));
        run_random(200);

        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("run covered %0d words: %0d detector updates, %0d ticks, %0d timeouts",
                 words_sent, n_updates, n_ticks, n_timeouts);
        $display("%0d result words checked, controller states visited %b",
                 results_seen, states_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
